// ===== sv/buvw_pkg.sv =====
// Shared constants and CORDIC angle table for the baseline uvw projection.
`default_nettype none
package buvw_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF     = 32;
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int POS_BITS  = 31;
  localparam int HA_BITS   = 16;
  localparam int DEC_BITS  = 16;
  localparam int BASE_BITS = POS_BITS + 1;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

  // Configuration port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_DECLINATION = 1'b0;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
    logic signed [CORDIC_W-1:0] a;
    case (i)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      24: a = 34'sd41;
      25: a = 34'sd20;
      26: a = 34'sd10;
      27: a = 34'sd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== sv/buvw_in_if.sv =====
// Input channel: antenna pair and hour angle.
`default_nettype none
interface buvw_in_if;
  import buvw_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [POS_BITS-1:0]  first_x;
  logic signed [POS_BITS-1:0]  first_y;
  logic signed [POS_BITS-1:0]  first_z;
  logic signed [POS_BITS-1:0]  second_x;
  logic signed [POS_BITS-1:0]  second_y;
  logic signed [POS_BITS-1:0]  second_z;
  logic        [HA_BITS-1:0]   hour_angle;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  hour_angle, input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  hour_angle, output ready);
endinterface
`default_nettype wire

// ===== sv/buvw_out_if.sv =====
// Output channel: projected u, v, w and saturation flag.
`default_nettype none
interface buvw_out_if #(
  parameter int COORD_BITS = buvw_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  u_coord;
  logic signed [COORD_BITS-1:0]  v_coord;
  logic signed [COORD_BITS-1:0]  w_coord;
  logic                          saturated;

  modport source (output valid, u_coord, v_coord, w_coord, saturated, input ready);
  modport sink   (input valid, u_coord, v_coord, w_coord, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/baseline_uvw_projection.sv =====
// Top level: pipelined baseline rotation into u, v, w with two CORDIC sine/cosine chains.
//
//   channel | dir | handshake        | word
//   in_i    | in  | valid/ready      | two antenna positions, hour angle
//   out_o   | out | valid/ready      | u, v, w, saturated
//   apb     | in  | psel/penable     | declination register
//
// One word per cycle unless the output stalls. The pipeline is the baseline
// stage, 28 unrolled CORDIC stages, then rounding, matrix, product, sum
// and finish stages. Reset clears the valid bits and the declination.
// A stall at the output freezes every stage at once; nothing is dropped.
`default_nettype none
module baseline_uvw_projection #(
  parameter int COORD_BITS     = buvw_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS     = buvw_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = buvw_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  buvw_in_if.sink                                 in_i,
  buvw_out_if.source                              out_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [buvw_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [buvw_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [buvw_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready
);
  import buvw_pkg::*;

  localparam int TF  = TRIG_FRAC_BITS;
  localparam int TW  = TF + 2;
  localparam int PW  = TW + BASE_BITS;
  localparam int SW  = PW + 2;
  localparam int CS  = CORDIC_FRAC - TF;
  localparam int NS  = CORDIC_STEPS + 6;
  localparam int S_T = CORDIC_STEPS + 1;
  localparam int S_M = CORDIC_STEPS + 2;
  localparam int S_P = CORDIC_STEPS + 3;
  localparam int S_S = CORDIC_STEPS + 4;
  localparam int S_O = CORDIC_STEPS + 5;

  localparam logic signed [CORDIC_W-1:0] C_HALF = CORDIC_W'(64'sd1 <<< (CS - 1));
  localparam logic signed [CORDIC_W-1:0] C_ONE  = CORDIC_W'(64'sd1 <<< TF);
  localparam logic signed [2*TW-1:0]     M_HALF = (2*TW)'(64'sd1 <<< (TF - 1));
  localparam logic signed [SW-1:0]       S_HALF = SW'(64'sd1 <<< (TF - 1));
  localparam logic signed [SW-1:0]       LIM    = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);

  // ---------------- configuration ----------------
  logic signed [DEC_BITS-1:0] decl_q;
  logic                       cfg_hit;

  assign cfg_hit = (paddr[APB_ADDR_BITS-1:2] == REG_DECLINATION);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? APB_DATA_BITS'(decl_q) : '0;

  // Write the declination on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= '0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      decl_q <= pwdata[DEC_BITS-1:0];
    end
  end

  // ---------------- flow control ----------------
  logic [NS-1:0] vld_q;
  logic          en;

  assign en          = !vld_q[NS-1] || out_o.ready;
  assign in_i.ready  = en;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  // ---------------- helpers ----------------
  function automatic logic [1:0] quad_of(input logic [31:0] ph);
    logic [31:0] t;
    t = ph + 32'h2000_0000;
    return t[31:30];
  endfunction

  function automatic logic signed [CORDIC_W-1:0] z_of(input logic [31:0] ph);
    logic [31:0] rr;
    rr = ph - {quad_of(ph), 30'b0};
    return CORDIC_W'($signed(rr));
  endfunction

  function automatic logic [31:0] phase_of(input logic [31:0] a);
    logic [31:0] p;
    p = '0;
    p[31 -: ANGLE_BITS] = a[ANGLE_BITS-1:0];
    return p;
  endfunction

  function automatic logic signed [TW-1:0] trig_round(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + C_HALF) >>> CS;
    if (r > C_ONE) r = C_ONE;
    if (r < -C_ONE) r = -C_ONE;
    return r[TW-1:0];
  endfunction

  function automatic logic signed [TW-1:0] mat_round(input logic signed [TW-1:0] a,
                                                     input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = (a * b + M_HALF) >>> TF;
    return p[TW-1:0];
  endfunction

  // ---------------- stage 0: baseline and phase setup ----------------
  logic signed [BASE_BITS-1:0] bx_q [0:S_P-1];
  logic signed [BASE_BITS-1:0] by_q [0:S_P-1];
  logic signed [BASE_BITS-1:0] bz_q [0:S_P-1];
  logic [1:0]                  hq_q [0:CORDIC_STEPS];
  logic [1:0]                  dq_q [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]  hx_q [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]  hy_q [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]  hz_q [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]  dx_q [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]  dy_q [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]  dz_q [0:CORDIC_STEPS];
  logic [31:0]                 ha_ph, de_ph;

  assign ha_ph = phase_of({{(32-HA_BITS){1'b0}}, in_i.hour_angle});
  assign de_ph = phase_of({{(32-DEC_BITS){decl_q[DEC_BITS-1]}}, decl_q});

  // Form baseline and reduce both angles to one quadrant
  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_q[0] <= BASE_BITS'(in_i.second_x) - BASE_BITS'(in_i.first_x);
      by_q[0] <= BASE_BITS'(in_i.second_y) - BASE_BITS'(in_i.first_y);
      bz_q[0] <= BASE_BITS'(in_i.second_z) - BASE_BITS'(in_i.first_z);
      hq_q[0] <= quad_of(ha_ph);
      dq_q[0] <= quad_of(de_ph);
      hz_q[0] <= z_of(ha_ph);
      dz_q[0] <= z_of(de_ph);
      hx_q[0] <= CORDIC_GAIN_INV;
      dx_q[0] <= CORDIC_GAIN_INV;
      hy_q[0] <= '0;
      dy_q[0] <= '0;
    end
  end

  // Carry the baseline down to the product stage
  for (genvar k = 1; k < S_P; k++) begin : g_base
    always_ff @(posedge clk_i) begin
      if (en) begin
        bx_q[k] <= bx_q[k-1];
        by_q[k] <= by_q[k-1];
        bz_q[k] <= bz_q[k-1];
      end
    end
  end

  // ---------------- CORDIC stages ----------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CORDIC_W-1:0] atan_c;
    assign atan_c = atan_turn(i);

    // Rotate both vectors one micro-step
    always_ff @(posedge clk_i) begin
      if (en) begin
        hq_q[i+1] <= hq_q[i];
        dq_q[i+1] <= dq_q[i];
        if (hz_q[i] >= 0) begin
          hx_q[i+1] <= hx_q[i] - (hy_q[i] >>> i);
          hy_q[i+1] <= hy_q[i] + (hx_q[i] >>> i);
          hz_q[i+1] <= hz_q[i] - atan_c;
        end else begin
          hx_q[i+1] <= hx_q[i] + (hy_q[i] >>> i);
          hy_q[i+1] <= hy_q[i] - (hx_q[i] >>> i);
          hz_q[i+1] <= hz_q[i] + atan_c;
        end
        if (dz_q[i] >= 0) begin
          dx_q[i+1] <= dx_q[i] - (dy_q[i] >>> i);
          dy_q[i+1] <= dy_q[i] + (dx_q[i] >>> i);
          dz_q[i+1] <= dz_q[i] - atan_c;
        end else begin
          dx_q[i+1] <= dx_q[i] + (dy_q[i] >>> i);
          dy_q[i+1] <= dy_q[i] - (dx_q[i] >>> i);
          dz_q[i+1] <= dz_q[i] + atan_c;
        end
      end
    end
  end

  // ---------------- trig rounding and quadrant fold ----------------
  logic signed [TW-1:0] hc_r, hs_r, dc_r, ds_r;
  logic signed [TW-1:0] ch_q, sh_q, cd_q, sd_q;

  assign hc_r = trig_round(hx_q[CORDIC_STEPS]);
  assign hs_r = trig_round(hy_q[CORDIC_STEPS]);
  assign dc_r = trig_round(dx_q[CORDIC_STEPS]);
  assign ds_r = trig_round(dy_q[CORDIC_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      case (hq_q[CORDIC_STEPS])
        2'd0:    begin ch_q <= hc_r;  sh_q <= hs_r;  end
        2'd1:    begin ch_q <= -hs_r; sh_q <= hc_r;  end
        2'd2:    begin ch_q <= -hc_r; sh_q <= -hs_r; end
        default: begin ch_q <= hs_r;  sh_q <= -hc_r; end
      endcase
      case (dq_q[CORDIC_STEPS])
        2'd0:    begin cd_q <= dc_r;  sd_q <= ds_r;  end
        2'd1:    begin cd_q <= -ds_r; sd_q <= dc_r;  end
        2'd2:    begin cd_q <= -dc_r; sd_q <= -ds_r; end
        default: begin cd_q <= ds_r;  sd_q <= -dc_r; end
      endcase
    end
  end

  // ---------------- rotation matrix ----------------
  logic signed [TW-1:0] m10_q, m11_q, m20_q, m21_q;
  logic signed [TW-1:0] ch2_q, nsh2_q, cd2_q, sd2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m10_q  <= -mat_round(sd_q, ch_q);
      m11_q  <= -mat_round(sd_q, sh_q);
      m20_q  <= mat_round(cd_q, ch_q);
      m21_q  <= mat_round(cd_q, sh_q);
      ch2_q  <= ch_q;
      nsh2_q <= -sh_q;
      cd2_q  <= cd_q;
      sd2_q  <= sd_q;
    end
  end

  // ---------------- products ----------------
  logic signed [PW-1:0] pu0_q, pu1_q, pv0_q, pv1_q, pv2_q, pw0_q, pw1_q, pw2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pu0_q <= PW'(nsh2_q) * PW'(bx_q[S_P-1]);
      pu1_q <= PW'(ch2_q)  * PW'(by_q[S_P-1]);
      pv0_q <= PW'(m10_q)  * PW'(bx_q[S_P-1]);
      pv1_q <= PW'(m11_q)  * PW'(by_q[S_P-1]);
      pv2_q <= PW'(cd2_q)  * PW'(bz_q[S_P-1]);
      pw0_q <= PW'(m20_q)  * PW'(bx_q[S_P-1]);
      pw1_q <= PW'(m21_q)  * PW'(by_q[S_P-1]);
      pw2_q <= PW'(sd2_q)  * PW'(bz_q[S_P-1]);
    end
  end

  // ---------------- sums ----------------
  logic signed [SW-1:0] su_q, sv_q, sw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      su_q <= SW'(pu0_q) + SW'(pu1_q);
      sv_q <= SW'(pv0_q) + SW'(pv1_q) + SW'(pv2_q);
      sw_q <= SW'(pw0_q) + SW'(pw1_q) + SW'(pw2_q);
    end
  end

  // ---------------- round, clip, output register ----------------
  logic signed [SW-1:0]         ru, rv, rw;
  logic signed [SW-1:0]         cu, cv, cw;
  logic                         su_flag, sv_flag, sw_flag;
  logic signed [COORD_BITS-1:0] u_q, v_q, w_q;
  logic                         sat_q;

  assign ru = (su_q + S_HALF) >>> TF;
  assign rv = (sv_q + S_HALF) >>> TF;
  assign rw = (sw_q + S_HALF) >>> TF;

  always_comb begin
    su_flag = (ru > LIM) || (ru < -LIM);
    sv_flag = (rv > LIM) || (rv < -LIM);
    sw_flag = (rw > LIM) || (rw < -LIM);
    cu = (ru > LIM) ? LIM : ((ru < -LIM) ? -LIM : ru);
    cv = (rv > LIM) ? LIM : ((rv < -LIM) ? -LIM : rv);
    cw = (rw > LIM) ? LIM : ((rw < -LIM) ? -LIM : rw);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q   <= cu[COORD_BITS-1:0];
      v_q   <= cv[COORD_BITS-1:0];
      w_q   <= cw[COORD_BITS-1:0];
      sat_q <= su_flag || sv_flag || sw_flag;
    end
  end

  assign out_o.valid     = vld_q[S_O];
  assign out_o.u_coord   = u_q;
  assign out_o.v_coord   = v_q;
  assign out_o.w_coord   = w_q;
  assign out_o.saturated = sat_q;

  // ---------------- assertions ----------------
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (SW'(out_o.u_coord) == LIM || SW'(out_o.u_coord) == -LIM ||
       SW'(out_o.v_coord) == LIM || SW'(out_o.v_coord) == -LIM ||
       SW'(out_o.w_coord) == LIM || SW'(out_o.w_coord) == -LIM))
    else $error("saturation flag without a clipped component");

endmodule
`default_nettype wire
